// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clock; ASSERT_CLKD is also reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define ASSERT_CLKD(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check prop at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: sv/vat_pkg.sv
// ----------------------------------------------------------------------------
// vat_pkg
// Widths, register and operation codes, and lane types for the vertex
// affine transform core.
// ----------------------------------------------------------------------------
package vat_pkg;

   localparam int COORD_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int TRIG_W    = 18;
   localparam int PROD_A_W  = 2 * COORD_W;
   localparam int PROD_B_W  = COORD_W + TRIG_W;
   localparam int SUM_W     = PROD_A_W + 1;

   // 1.0 in the coordinate and trig formats
   localparam logic signed [COORD_W-1:0] ONE_COORD = COORD_W'(1) << FRAC_BITS;
   localparam logic signed [TRIG_W-1:0]  ONE_TRIG  = TRIG_W'(1) << FRAC_BITS;
   localparam logic signed [SUM_W-1:0]   HALF_LSB  = SUM_W'(1) << (FRAC_BITS - 1);

   // Operation codes
   localparam logic [2:0] OP_MOVE_X   = 3'd0;
   localparam logic [2:0] OP_MOVE_Y   = 3'd1;
   localparam logic [2:0] OP_MOVE_Z   = 3'd2;
   localparam logic [2:0] OP_ROTATE_X = 3'd3;
   localparam logic [2:0] OP_ROTATE_Y = 3'd4;
   localparam logic [2:0] OP_ROTATE_Z = 3'd5;
   localparam logic [2:0] OP_SCALE    = 3'd6;

   // Register indexes
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_OPERATION    = 3'd0;
   localparam logic [2:0] REG_SHIFT_OFFSET = 3'd1;
   localparam logic [2:0] REG_COSINE_VALUE = 3'd2;
   localparam logic [2:0] REG_SINE_VALUE   = 3'd3;
   localparam logic [2:0] REG_SCALE_RATIO  = 3'd4;

   // One output axis: a*ka +/- b*kb
   typedef struct packed {
      logic signed [COORD_W-1:0] a;
      logic signed [COORD_W-1:0] ka;
      logic signed [COORD_W-1:0] b;
      logic signed [TRIG_W-1:0]  kb;
      logic                      sub;
   } lane_operand_type;

   typedef struct packed {
      logic ld_mul;
      logic ld_out;
   } lane_ctrl_type;

endpackage

// File: sv/vertex_affine_transform_core.sv
// ----------------------------------------------------------------------------
// vertex_affine_transform_core
// Streaming move / rotate / scale of Q15.16 vertices with saturation.
// ----------------------------------------------------------------------------
// Takes one vertex per clock while the result side is ready, and returns
// it from the output register. Stage one picks the operands for each axis
// from the operation register, stage two forms the two products of each axis
// (up to 32x32 bits), stage three sums, rounds half up and saturates; the
// third stage is the output register. Stages hold their item while the next
// one is full, so bubbles close up and a stall loses nothing. The registers
// are read only at stage one: write them while no transaction is in flight.
module vertex_affine_transform_core
   import vat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: in_x [31:0], in_y [63:32], in_z [95:64]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [3*COORD_W-1:0]  req_tdata,
   // rsp_tdata: out_x [31:0], out_y [63:32], out_z [95:64]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [3*COORD_W-1:0]  rsp_tdata,
   // rsp_tuser: clipped [0]
   output logic                  rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

`include "assert_macros.svh"

   // Configuration registers
   logic [2:0]                operation_ff;
   logic signed [COORD_W-1:0] shift_offset_ff;
   logic signed [TRIG_W-1:0]  cosine_value_ff;
   logic signed [TRIG_W-1:0]  sine_value_ff;
   logic signed [COORD_W-1:0] scale_ratio_ff;

   logic       csr_wr;
   logic [2:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff    <= OP_MOVE_X;
         shift_offset_ff <= '0;
         cosine_value_ff <= ONE_TRIG;
         sine_value_ff   <= '0;
         scale_ratio_ff  <= ONE_COORD;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_OPERATION:    operation_ff    <= csr_pwdata[2:0];
            REG_SHIFT_OFFSET: shift_offset_ff <= csr_pwdata[COORD_W-1:0];
            REG_COSINE_VALUE: cosine_value_ff <= csr_pwdata[TRIG_W-1:0];
            REG_SINE_VALUE:   sine_value_ff   <= csr_pwdata[TRIG_W-1:0];
            REG_SCALE_RATIO:  scale_ratio_ff  <= csr_pwdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_OPERATION:    csr_prdata = {29'd0, operation_ff};
         REG_SHIFT_OFFSET: csr_prdata = 32'(shift_offset_ff);
         REG_COSINE_VALUE: csr_prdata = {{(32-TRIG_W){1'b0}}, cosine_value_ff};
         REG_SINE_VALUE:   csr_prdata = {{(32-TRIG_W){1'b0}}, sine_value_ff};
         REG_SCALE_RATIO:  csr_prdata = 32'(scale_ratio_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Pipeline control: a stage loads when it is empty or the next one loads
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic ld1, ld2, ld3;

   assign ld3        = !s3_valid_ff || rsp_tready;
   assign ld2        = !s2_valid_ff || ld3;
   assign ld1        = !s1_valid_ff || ld2;
   assign req_tready = ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (ld1) s1_valid_ff <= req_tvalid;
         if (ld2) s2_valid_ff <= s1_valid_ff;
         if (ld3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage one: operand select
   logic signed [COORD_W-1:0] in_x, in_y, in_z;
   logic signed [COORD_W-1:0] cos_w, sin_w;
   lane_operand_type          opnd_x_in, opnd_y_in, opnd_z_in;
   lane_operand_type          opnd_x_ff, opnd_y_ff, opnd_z_ff;

   assign in_x  = req_tdata[0*COORD_W +: COORD_W];
   assign in_y  = req_tdata[1*COORD_W +: COORD_W];
   assign in_z  = req_tdata[2*COORD_W +: COORD_W];
   assign cos_w = COORD_W'(cosine_value_ff);
   assign sin_w = COORD_W'(sine_value_ff);

   always_comb begin
      // pass every axis through by default: a * 1.0
      opnd_x_in = '{a: in_x, ka: ONE_COORD, b: '0, kb: '0, sub: 1'b0};
      opnd_y_in = '{a: in_y, ka: ONE_COORD, b: '0, kb: '0, sub: 1'b0};
      opnd_z_in = '{a: in_z, ka: ONE_COORD, b: '0, kb: '0, sub: 1'b0};
      case (operation_ff)
         OP_MOVE_X: begin
            opnd_x_in.b  = shift_offset_ff;
            opnd_x_in.kb = ONE_TRIG;
         end
         OP_MOVE_Y: begin
            opnd_y_in.b  = shift_offset_ff;
            opnd_y_in.kb = ONE_TRIG;
         end
         OP_MOVE_Z: begin
            opnd_z_in.b  = shift_offset_ff;
            opnd_z_in.kb = ONE_TRIG;
         end
         OP_ROTATE_X: begin
            opnd_y_in = '{a: in_y, ka: cos_w, b: in_z, kb: sine_value_ff, sub: 1'b1};
            opnd_z_in = '{a: in_y, ka: sin_w, b: in_z, kb: cosine_value_ff, sub: 1'b0};
         end
         OP_ROTATE_Y: begin
            opnd_x_in = '{a: in_x, ka: cos_w, b: in_z, kb: sine_value_ff, sub: 1'b0};
            opnd_z_in = '{a: in_z, ka: cos_w, b: in_x, kb: sine_value_ff, sub: 1'b1};
         end
         OP_ROTATE_Z: begin
            opnd_x_in = '{a: in_x, ka: cos_w, b: in_y, kb: sine_value_ff, sub: 1'b1};
            opnd_y_in = '{a: in_x, ka: sin_w, b: in_y, kb: cosine_value_ff, sub: 1'b0};
         end
         OP_SCALE: begin
            // zero ratio leaves the vertex as is
            if (scale_ratio_ff != '0) begin
               opnd_x_in.ka = scale_ratio_ff;
               opnd_y_in.ka = scale_ratio_ff;
               opnd_z_in.ka = scale_ratio_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         opnd_x_ff <= opnd_x_in;
         opnd_y_ff <= opnd_y_in;
         opnd_z_ff <= opnd_z_in;
      end
   end

   // Stages two and three: one lane per axis
   lane_ctrl_type             lane_ctrl;
   logic signed [COORD_W-1:0] out_x, out_y, out_z;
   logic                      clip_x, clip_y, clip_z;

   assign lane_ctrl = '{ld_mul: ld2, ld_out: ld3};

   vat_lane u_lane_x (
      .clock  (clock),
      .ctrl   (lane_ctrl),
      .opnd   (opnd_x_ff),
      .result (out_x),
      .clip   (clip_x)
   );

   vat_lane u_lane_y (
      .clock  (clock),
      .ctrl   (lane_ctrl),
      .opnd   (opnd_y_ff),
      .result (out_y),
      .clip   (clip_y)
   );

   vat_lane u_lane_z (
      .clock  (clock),
      .ctrl   (lane_ctrl),
      .opnd   (opnd_z_ff),
      .result (out_z),
      .clip   (clip_z)
   );

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = {out_z, out_y, out_x};
   assign rsp_tuser  = clip_x || clip_y || clip_z;

   // Assertions
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   `ASSERT_CLKD(a_accept_enters, req_tvalid && req_tready |=> s1_valid_ff,
      "accepted transaction did not enter stage one")
   `ASSERT_CLKD(a_stall_holds, s1_valid_ff && !ld2 |=> s1_valid_ff && s2_valid_ff,
      "stalled item dropped from stage one")
   `ASSERT_CLKD(a_full_when_busy,
      !req_tready |-> s1_valid_ff && s2_valid_ff && s3_valid_ff && !rsp_tready,
      "input held off while the pipeline has room")
   `ASSERT_CLKD(a_clip_saturates,
      rsp_tvalid && rsp_tuser |-> (out_x == COORD_MAX) || (out_x == COORD_MIN) ||
         (out_y == COORD_MAX) || (out_y == COORD_MIN) ||
         (out_z == COORD_MAX) || (out_z == COORD_MIN),
      "clipped flag set without a saturated coordinate")

endmodule

// File: sv/vat_lane.sv
// ----------------------------------------------------------------------------
// vat_lane
// One coordinate lane: two products, then sum, round half up and saturate.
// ----------------------------------------------------------------------------
module vat_lane
   import vat_pkg::*;
(
   input  logic                      clock,
   input  lane_ctrl_type             ctrl,
   input  lane_operand_type          opnd,
   output logic signed [COORD_W-1:0] result,
   output logic                      clip
);

   localparam int HI_W = SUM_W - (FRAC_BITS + COORD_W - 1);

   logic signed [PROD_A_W-1:0] prod_a_ff;
   logic signed [PROD_B_W-1:0] prod_b_ff;
   logic                       sub_ff;
   logic signed [COORD_W-1:0]  result_ff;
   logic                       clip_ff;

   logic signed [SUM_W-1:0]    sum_in;
   logic [HI_W-1:0]            hi_bits;
   logic                       ovf;
   logic signed [COORD_W-1:0]  result_in;

   always_ff @(posedge clock) begin
      if (ctrl.ld_mul) begin
         prod_a_ff <= opnd.a * opnd.ka;
         prod_b_ff <= opnd.b * PROD_B_W'(opnd.kb);
         sub_ff    <= opnd.sub;
      end
   end

   always_comb begin
      if (sub_ff) begin
         sum_in = SUM_W'(prod_a_ff) - SUM_W'(prod_b_ff) + HALF_LSB;
      end else begin
         sum_in = SUM_W'(prod_a_ff) + SUM_W'(prod_b_ff) + HALF_LSB;
      end
      // bits above the kept window must all match the sign
      hi_bits = sum_in[SUM_W-1 -: HI_W];
      ovf     = (hi_bits != '0) && (hi_bits != '1);
      if (!ovf) begin
         result_in = sum_in[FRAC_BITS +: COORD_W];
      end else if (sum_in[SUM_W-1]) begin
         result_in = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         result_in = {1'b0, {(COORD_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_out) begin
         result_ff <= result_in;
         clip_ff   <= ovf;
      end
   end

   assign result = result_ff;
   assign clip   = clip_ff;

endmodule

// File: tb/vertex_affine_transform_core_tb.sv
// ----------------------------------------------------------------------------
// vertex_affine_transform_core_tb
// Self-checking bench for the streaming vertex move / rotate / scale core.
// A table of directed vertices walks the register extremes, every operation,
// rounding at the half LSB, saturation, zero ratio and the unused operation
// code. Random phases follow, each with fresh register values written over
// the config port while the pipeline is empty. Every accepted vertex is
// predicted in the bench and compared with the returned transaction, under
// random stalls on both channels.
// ----------------------------------------------------------------------------
module vertex_affine_transform_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vat_pkg::*;

   // unused operation code: vertex passes through
   localparam logic [2:0] OP_PASS = 3'd7;

   localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [TRIG_W-1:0]  T_MAX = {1'b0, {(TRIG_W-1){1'b1}}};
   localparam logic signed [TRIG_W-1:0]  T_MIN = {1'b1, {(TRIG_W-1){1'b0}}};

   localparam int RANDOM_ITEMS  = 1450;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic signed [COORD_W-1:0] x, y, z;
   } vertex_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x, y, z;
      logic                      clipped;
   } point_out_type;

   typedef struct packed {
      logic [2:0]                op;
      logic signed [COORD_W-1:0] offset;
      logic signed [TRIG_W-1:0]  cosv, sinv;
      logic signed [COORD_W-1:0] ratio;
   } xform_cfg_type;

   typedef struct packed {
      xform_cfg_type cfg;
      vertex_type    v;
      logic          known;
      point_out_type want;
   } stim_row_type;

   localparam xform_cfg_type CFG_RESET =
      '{OP_MOVE_X, 32'sd0, 18'sd65536, 18'sd0, 32'sd65536};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // in_x [31:0], in_y [63:32], in_z [95:64]
   logic [3*COORD_W-1:0]  req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // out_x [31:0], out_y [63:32], out_z [95:64]
   logic [3*COORD_W-1:0]  rsp_tdata;
   // clipped [0]
   logic                  rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   xform_cfg_type cfg = CFG_RESET;
   point_out_type expected_points[$];
   logic          steady = 1'b0;
   int            mismatch_count = 0;
   int            results_seen = 0;
   int            items_sent = 0;
   int            config_count = 0;

   stim_row_type stim_table [0:19] = '{
      // registers as after reset
      '{CFG_RESET, '{32'sd65536, -32'sd65536, 32'sd1}, 1'b1,
        '{32'sd65536, -32'sd65536, 32'sd1, 1'b0}},
      '{'{OP_MOVE_X, C_MAX, 18'sd65536, 18'sd0, 32'sd65536}, '{C_MAX, 32'sd0, C_MIN},
        1'b1, '{C_MAX, 32'sd0, C_MIN, 1'b1}},
      '{'{OP_MOVE_Y, C_MIN, 18'sd65536, 18'sd0, 32'sd65536}, '{32'sd1, C_MIN, C_MAX},
        1'b1, '{32'sd1, C_MIN, C_MAX, 1'b1}},
      '{'{OP_MOVE_Z, C_MIN, 18'sd65536, 18'sd0, 32'sd65536}, '{32'sd0, 32'sd0, C_MAX},
        1'b1, '{32'sd0, 32'sd0, -32'sd1, 1'b0}},
      '{'{OP_MOVE_Z, 32'sd65536, 18'sd0, 18'sd0, 32'sd0}, '{32'sd5, 32'sd6, -32'sd65536},
        1'b0, '0},
      '{'{OP_ROTATE_X, 32'sd0, 18'sd65536, 18'sd0, 32'sd65536}, '{C_MAX, C_MIN, 32'sd12345},
        1'b1, '{C_MAX, C_MIN, 32'sd12345, 1'b0}},
      '{'{OP_ROTATE_Y, 32'sd0, 18'sd0, 18'sd65536, 32'sd65536},
        '{32'sd65536, 32'sd2, 32'sd196608}, 1'b0, '0},
      '{'{OP_ROTATE_Z, 32'sd0, -18'sd65536, -18'sd65536, 32'sd65536}, '{C_MAX, C_MAX, 32'sd7},
        1'b0, '0},
      '{'{OP_ROTATE_X, 32'sd0, T_MAX, T_MIN, 32'sd65536}, '{C_MIN, C_MIN, C_MAX}, 1'b0, '0},
      '{'{OP_ROTATE_Y, 32'sd0, T_MIN, T_MAX, 32'sd65536}, '{C_MAX, 32'sd0, C_MIN}, 1'b0, '0},
      '{'{OP_ROTATE_Z, 32'sd0, 18'sd46341, 18'sd46341, 32'sd65536}, '{32'sd1, 32'sd1, 32'sd1},
        1'b0, '0},
      // half an LSB in both directions
      '{'{OP_ROTATE_X, 32'sd0, 18'sd32768, 18'sd0, 32'sd65536}, '{32'sd9, 32'sd1, -32'sd1},
        1'b0, '0},
      '{'{OP_SCALE, 32'sd0, 18'sd65536, 18'sd0, 32'sd0}, '{C_MAX, C_MIN, -32'sd5}, 1'b1,
        '{C_MAX, C_MIN, -32'sd5, 1'b0}},
      '{'{OP_SCALE, 32'sd0, 18'sd65536, 18'sd0, C_MAX}, '{C_MAX, C_MIN, 32'sd0}, 1'b1,
        '{C_MAX, C_MIN, 32'sd0, 1'b1}},
      '{'{OP_SCALE, 32'sd0, 18'sd65536, 18'sd0, C_MIN}, '{C_MIN, C_MAX, 32'sd65536},
        1'b0, '0},
      '{'{OP_SCALE, 32'sd0, 18'sd65536, 18'sd0, 32'sd65536},
        '{32'sd123456789, -32'sd98765, 32'sd1}, 1'b1,
        '{32'sd123456789, -32'sd98765, 32'sd1, 1'b0}},
      '{'{OP_SCALE, 32'sd0, 18'sd65536, 18'sd0, 32'sd1}, '{32'sd32768, -32'sd32768, 32'sd98304},
        1'b0, '0},
      '{'{OP_SCALE, 32'sd0, 18'sd65536, 18'sd0, -32'sd65536}, '{C_MIN, 32'sd1, -32'sd1},
        1'b0, '0},
      '{'{OP_PASS, C_MAX, T_MIN, T_MAX, C_MIN}, '{C_MAX, C_MIN, 32'sd42}, 1'b1,
        '{C_MAX, C_MIN, 32'sd42, 1'b0}},
      '{'{OP_MOVE_X, -32'sd1, 18'sd65536, 18'sd0, 32'sd65536}, '{32'sd0, C_MAX, C_MIN},
        1'b0, '0}
   };

   vertex_affine_transform_core uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("timeout with %0d results still expected", expected_points.size());
      $display("end of test: mismatches");
      $finish;
   end

   function automatic logic signed [COORD_W-1:0] clamp(longint v, inout logic clip);
      if (v > longint'(C_MAX)) begin
         clip = 1'b1;
         return C_MAX;
      end
      if (v < longint'(C_MIN)) begin
         clip = 1'b1;
         return C_MIN;
      end
      return v[COORD_W-1:0];
   endfunction

   function automatic longint round_half_up(longint v);
      return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic point_out_type transform_vertex(vertex_type v, xform_cfg_type k);
      longint        x, y, z, off, c, s, r;
      logic          clip;
      point_out_type res;
      x = v.x;
      y = v.y;
      z = v.z;
      off = k.offset;
      c = k.cosv;
      s = k.sinv;
      r = k.ratio;
      clip = 1'b0;
      res = '{v.x, v.y, v.z, 1'b0};
      case (k.op)
         OP_MOVE_X: res.x = clamp(x + off, clip);
         OP_MOVE_Y: res.y = clamp(y + off, clip);
         OP_MOVE_Z: res.z = clamp(z + off, clip);
         OP_ROTATE_X: begin
            res.y = clamp(round_half_up(y * c - z * s), clip);
            res.z = clamp(round_half_up(y * s + z * c), clip);
         end
         OP_ROTATE_Y: begin
            res.x = clamp(round_half_up(x * c + z * s), clip);
            res.z = clamp(round_half_up(z * c - x * s), clip);
         end
         OP_ROTATE_Z: begin
            res.x = clamp(round_half_up(x * c - y * s), clip);
            res.y = clamp(round_half_up(x * s + y * c), clip);
         end
         OP_SCALE: begin
            // zero ratio leaves the vertex alone
            if (r != 0) begin
               res.x = clamp(round_half_up(x * r), clip);
               res.y = clamp(round_half_up(y * r), clip);
               res.z = clamp(round_half_up(z * r), clip);
            end
         end
         default: ;
      endcase
      res.clipped = clip;
      return res;
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(9))
         0:       return C_MAX;
         1:       return C_MIN;
         2, 3, 4: return COORD_W'(int'($urandom_range(1 << 21)) - (1 << 20));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic signed [TRIG_W-1:0] pick_trig();
      case ($urandom_range(9))
         0:       return T_MAX;
         1:       return T_MIN;
         2:       return ONE_TRIG;
         3:       return -ONE_TRIG;
         4:       return TRIG_W'($urandom());
         default: return TRIG_W'(int'($urandom_range(1 << 17)) - (1 << 16));
      endcase
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_ratio();
      case ($urandom_range(9))
         0:       return '0;
         1:       return ONE_COORD;
         2:       return C_MAX;
         3:       return C_MIN;
         4, 5, 6: return COORD_W'(int'($urandom_range(1 << 19)) - (1 << 18));
         7:       return $urandom();
         default: return COORD_W'(int'($urandom_range(1 << 17)) - (1 << 16));
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
   endtask

   // Queue the prediction as soon as the vertex is offered; its result
   // cannot show up before the transaction is taken.
   task automatic send_vertex(vertex_type v, point_out_type want);
      while (!steady && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {v.z, v.y, v.x};
      expected_points.push_back(want);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves psel high so that back-to-back writes do not toggle it.
   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic apply_config(xform_cfg_type k);
      if (k == cfg) return;
      drain();
      write_reg(REG_OPERATION, 32'(k.op));
      write_reg(REG_SHIFT_OFFSET, k.offset);
      write_reg(REG_COSINE_VALUE, 32'(k.cosv));
      write_reg(REG_SINE_VALUE, 32'(k.sinv));
      write_reg(REG_SCALE_RATIO, k.ratio);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cfg = k;
      config_count++;
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin
      point_out_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser};
         results_seen++;
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected transaction, out_x", '0, got.x);
         end else begin
            want = expected_points.pop_front();
            if (got.x !== want.x) report_mismatch("out_x", want.x, got.x);
            if (got.y !== want.y) report_mismatch("out_y", want.y, got.y);
            if (got.z !== want.z) report_mismatch("out_z", want.z, got.z);
            if (got.clipped !== want.clipped)
               report_mismatch("clipped", 32'(want.clipped), 32'(got.clipped));
         end
      end
   end

   initial begin
      xform_cfg_type k;
      vertex_type    v;
      int            goal;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i]) begin
         apply_config(stim_table[i].cfg);
         send_vertex(stim_table[i].v, stim_table[i].known ? stim_table[i].want
                                                          : transform_vertex(stim_table[i].v, cfg));
      end

      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         k.op = 3'($urandom_range(7));
         k.offset = pick_coord();
         k.cosv = pick_trig();
         k.sinv = pick_trig();
         k.ratio = pick_ratio();
         apply_config(k);
         // hold both channels busy for a stretch in the middle
         steady = (items_sent >= goal - 900) && (items_sent < goal - 700);
         repeat ($urandom_range(60, 10)) begin
            v = '{pick_coord(), pick_coord(), pick_coord()};
            send_vertex(v, transform_vertex(v, cfg));
         end
      end
      steady = 1'b0;
      drain();

      $display("%0d vertices checked under %0d register settings", results_seen, config_count);
      $display("covered move, rotate, scale, zero ratio and the unused operation code");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
